/* rtl/utc_pkg.sv */
// ----------------------------------------------------------------------------
// utc_pkg
// Shared types and constants of the UTF-16 to UTF-8 converter.
// ----------------------------------------------------------------------------
package utc_pkg;

  localparam logic [7:0]  BOM_FE     = 8'hFE;
  localparam logic [7:0]  BOM_FF     = 8'hFF;
  localparam logic [15:0] ONE_LIMIT  = 16'h0080;
  localparam logic [15:0] TWO_LIMIT  = 16'h0800;
  localparam logic [2:0]  LEAD2_TAG  = 3'b110;
  localparam logic [3:0]  LEAD3_TAG  = 4'b1110;
  localparam logic [1:0]  CONT_TAG   = 2'b10;
  localparam int          MAX_BYTES  = 3;

  // Bytes of one encoded code unit; bytes[0] goes out first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                cnt;
    logic                      fin;
  } utc_entry_t;

  function automatic logic is_bom(input logic [7:0] first, input logic [7:0] second);
    is_bom = ((first == BOM_FE) && (second == BOM_FF)) ||
             ((first == BOM_FF) && (second == BOM_FE));
  endfunction

endpackage

/* rtl/utc_decode.sv */
// ----------------------------------------------------------------------------
// utc_decode
// Byte-order-mark tracking, byte pairing and UTF-8 encoding of one code unit.
// ----------------------------------------------------------------------------
module utc_decode
  import utc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output utc_entry_t entry_o
);

  logic       big_q, big_d;
  logic       seen_q, seen_d;
  logic       half_q, half_d;
  logic [7:0] held_q, held_d;
  logic [7:0] prev_q, prev_d;
  logic       prev_vld_q, prev_vld_d;

  logic        emit;
  logic [15:0] unit;

  always_comb begin
    big_d      = big_q;
    seen_d     = seen_q;
    half_d     = half_q;
    held_d     = held_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    emit       = 1'b0;
    if (!seen_q) begin
      if (prev_vld_q && is_bom(prev_q, data_byte_i)) begin
        big_d      = (prev_q == BOM_FE);
        seen_d     = 1'b1;
        half_d     = 1'b0;
        prev_vld_d = 1'b0;
      end else begin
        prev_d     = data_byte_i;
        prev_vld_d = 1'b1;
      end
    end else if (!half_q) begin
      held_d = data_byte_i;
      half_d = 1'b1;
    end else begin
      half_d = 1'b0;
      if (is_bom(held_q, data_byte_i)) begin
        big_d = (held_q == BOM_FE);
      end else begin
        emit = 1'b1;
      end
    end
    if (final_byte_i) begin
      big_d      = 1'b0;
      seen_d     = 1'b0;
      half_d     = 1'b0;
      held_d     = '0;
      prev_d     = '0;
      prev_vld_d = 1'b0;
    end
  end

  assign unit = big_q ? {held_q, data_byte_i} : {data_byte_i, held_q};

  always_comb begin
    entry_o       = '0;
    entry_o.fin   = final_byte_i;
    if (!emit) begin
      entry_o.cnt = 2'd0;
    end else if (unit < ONE_LIMIT) begin
      entry_o.cnt      = 2'd1;
      entry_o.bytes[0] = unit[7:0];
    end else if (unit < TWO_LIMIT) begin
      entry_o.cnt      = 2'd2;
      entry_o.bytes[0] = {LEAD2_TAG, unit[10:6]};
      entry_o.bytes[1] = {CONT_TAG, unit[5:0]};
    end else begin
      entry_o.cnt      = 2'd3;
      entry_o.bytes[0] = {LEAD3_TAG, unit[15:12]};
      entry_o.bytes[1] = {CONT_TAG, unit[11:6]};
      entry_o.bytes[2] = {CONT_TAG, unit[5:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_q      <= 1'b0;
      seen_q     <= 1'b0;
      half_q     <= 1'b0;
      held_q     <= '0;
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
    end else if (fire_i) begin
      big_q      <= big_d;
      seen_q     <= seen_d;
      half_q     <= half_d;
      held_q     <= held_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
    end
  end

endmodule

/* rtl/utc_serial.sv */
// ----------------------------------------------------------------------------
// utc_serial
// One-entry holding slot and byte serializer driving the output stream.
// ----------------------------------------------------------------------------
module utc_serial
  import utc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  utc_entry_t entry_i,
  output logic       free_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o,
  output logic       m_axis_tuser_o
);

  logic       slot_vld_q, slot_vld_d;
  utc_entry_t slot_q, slot_d;
  logic       ser_vld_q, ser_vld_d;
  utc_entry_t ser_q, ser_d;
  logic       out_fire;
  logic       ser_take;

  assign out_fire = ser_vld_q && m_axis_tready_i;
  assign ser_take = !ser_vld_q || (out_fire && (ser_q.cnt == 2'd1));
  assign free_o   = !slot_vld_q || ser_take;

  always_comb begin
    slot_vld_d = slot_vld_q;
    slot_d     = slot_q;
    ser_vld_d  = ser_vld_q;
    ser_d      = ser_q;
    if (ser_take) begin
      ser_vld_d = slot_vld_q;
      ser_d     = slot_q;
      if (slot_vld_q) begin
        slot_vld_d = 1'b0;
      end
    end else if (out_fire) begin
      ser_d.bytes[0] = ser_q.bytes[1];
      ser_d.bytes[1] = ser_q.bytes[2];
      ser_d.cnt      = ser_q.cnt - 2'd1;
    end
    if (load_i) begin
      slot_vld_d = 1'b1;
      slot_d     = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= 1'b0;
      ser_vld_q  <= 1'b0;
    end else begin
      slot_vld_q <= slot_vld_d;
      ser_vld_q  <= ser_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    ser_q  <= ser_d;
  end

  assign m_axis_tvalid_o = ser_vld_q;
  assign m_axis_tdata_o  = ser_q.bytes[0];
  assign m_axis_tlast_o  = (ser_q.cnt == 2'd1);
  assign m_axis_tuser_o  = ser_q.fin;

endmodule

/* rtl/utf16_to_utf8_converter.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_converter
// UTF-16 byte stream to UTF-8 byte stream, byte order from the mark.
// ----------------------------------------------------------------------------
// Takes one UTF-16 byte per item and, once a byte-order mark has been seen,
// emits the UTF-8 bytes of each completed code unit, one byte per cycle while
// the receiver is ready. An input byte is taken when valid meets ready and,
// while the output keeps up, a new one can follow in the next cycle. A
// completed unit goes to a holding slot, then to the output register, from
// which its first byte is offered. A code unit takes two input bytes and
// one to three output bytes; the input stalls only while both the slot and
// the output register are busy. tlast on the output closes the bytes of one
// input item, tuser flags those caused by the item marked tlast on the
// input, after which all state returns to reset.
module utf16_to_utf8_converter
  import utc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // final_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] utf8_byte
  output logic       m_axis_tlast_o,   // run_end
  output logic       m_axis_tuser_o    // [0] text_end
);

  logic       in_fire;
  logic       slot_free;
  utc_entry_t entry;

  assign s_axis_tready_o = slot_free;
  assign in_fire         = s_axis_tvalid_i && slot_free;

  utc_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .data_byte_i  (s_axis_tdata_i),
    .final_byte_i (s_axis_tlast_i),
    .entry_o      (entry)
  );

  utc_serial u_serial (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (in_fire && (entry.cnt != 2'd0)),
    .entry_i         (entry),
    .free_o          (slot_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* rtl/utc_checker.sv */
// ----------------------------------------------------------------------------
// utc_checker
// Port-level checks of the converter's output stream.
// ----------------------------------------------------------------------------
module utc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  logic       out_fire;
  logic [1:0] run_cnt_q;
  logic       run_user_q;

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q  <= 2'd0;
      run_user_q <= 1'b0;
    end else if (out_fire) begin
      run_cnt_q  <= m_axis_tlast_o ? 2'd0 : run_cnt_q + 2'd1;
      run_user_q <= m_axis_tuser_o;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("output item changed while stalled");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (run_cnt_q == 2'd2)) |-> m_axis_tlast_o)
    else $error("run longer than three bytes");

  a_run_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (run_cnt_q != 2'd0)) |-> (m_axis_tuser_o == run_user_q))
    else $error("text end flag changed inside a run");

endmodule

bind utf16_to_utf8_converter utc_checker u_utc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* verif/utf16_to_utf8_converter_tb.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_converter_tb
// Self-checking bench for the UTF-16 to UTF-8 converter.
// ----------------------------------------------------------------------------
// Feeds UTF-16 texts byte by byte: a few hand-picked texts covering the byte
// order marks, the encoding length boundaries, order switches, a dropped odd
// byte and a final byte with no output, then random texts, mostly a mark
// followed by code units of every length, some plain noise. A scoreboard
// predicts the UTF-8 bytes of each accepted item and checks every output item
// in order. Three phases run; both sides idle at random in the first two, in
// the last the output is held off for a long stretch so the input backs up.
// ----------------------------------------------------------------------------
module utf16_to_utf8_converter_tb;
  import utc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 470;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 300;
  localparam int DRAIN_WAIT  = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       run_end;
    logic       text_end;
  } utf8_item_t;

  class utf8_scoreboard;
    utf8_item_t utf8_pending[$];
    logic       big_endian;
    logic       mark_seen;
    logic       pair_half;
    logic [7:0] held_byte;
    logic [7:0] prev_byte;
    logic       prev_valid;
    int         n_inputs;
    int         n_checked;
    int         n_errors;

    function new();
      clear();
      n_inputs  = 0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void clear();
      big_endian = 1'b0;
      mark_seen  = 1'b0;
      pair_half  = 1'b0;
      held_byte  = '0;
      prev_byte  = '0;
      prev_valid = 1'b0;
    endfunction

    function logic is_order_mark(logic [7:0] first, logic [7:0] second);
      return (first == BOM_FE && second == BOM_FF) || (first == BOM_FF && second == BOM_FE);
    endfunction

    // Predicts the UTF-8 bytes of one accepted UTF-16 byte.
    function void note_utf16_byte(logic [7:0] b, logic fin);
      logic [7:0]  enc [3];
      logic [15:0] unit;
      int          n;
      utf8_item_t  it;
      n = 0;
      n_inputs++;
      if (!mark_seen) begin
        if (prev_valid && is_order_mark(prev_byte, b)) begin
          big_endian = (prev_byte == BOM_FE);
          mark_seen  = 1'b1;
          pair_half  = 1'b0;
          prev_valid = 1'b0;
        end else begin
          prev_byte  = b;
          prev_valid = 1'b1;
        end
      end else if (!pair_half) begin
        held_byte = b;
        pair_half = 1'b1;
      end else begin
        pair_half = 1'b0;
        if (is_order_mark(held_byte, b)) begin
          big_endian = (held_byte == BOM_FE);
        end else begin
          unit = big_endian ? {held_byte, b} : {b, held_byte};
          if (unit < ONE_LIMIT) begin
            enc[0] = unit[7:0];
            n = 1;
          end else if (unit < TWO_LIMIT) begin
            enc[0] = {LEAD2_TAG, unit[10:6]};
            enc[1] = {CONT_TAG, unit[5:0]};
            n = 2;
          end else begin
            enc[0] = {LEAD3_TAG, unit[15:12]};
            enc[1] = {CONT_TAG, unit[11:6]};
            enc[2] = {CONT_TAG, unit[5:0]};
            n = 3;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        it.code     = enc[k];
        it.run_end  = (k == n - 1);
        it.text_end = fin;
        utf8_pending.push_back(it);
      end
      if (fin) clear();
    endfunction

    function void check_utf8_byte(logic [7:0] code, logic run_end, logic text_end);
      utf8_item_t want;
      if (utf8_pending.size() == 0) begin
        $error("unexpected output item: utf8_byte %02h", code);
        n_errors++;
        return;
      end
      want = utf8_pending.pop_front();
      n_checked++;
      if (code !== want.code) begin
        $error("utf8_byte mismatch: expected %02h, actual %02h", want.code, code);
        n_errors++;
      end
      if (run_end !== want.run_end) begin
        $error("run_end mismatch: expected %0b, actual %0b", want.run_end, run_end);
        n_errors++;
      end
      if (text_end !== want.text_end) begin
        $error("text_end mismatch: expected %0b, actual %0b", want.text_end, text_end);
        n_errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic       s_axis_tlast;   // final_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] utf8_byte
  logic       m_axis_tlast;   // run_end
  logic       m_axis_tuser;   // [0] text_end

  utf8_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;
  int n_texts       = 0;
  int cycle_cnt     = 0;

  utf16_to_utf8_converter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random idling plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_utf8_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Entered at a falling edge; returns at the falling edge after acceptance.
  task automatic send_utf16_text(input logic [7:0] txt[$]);
    for (int i = 0; i < txt.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = txt[i];
      s_axis_tlast  = (i == txt.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      sb.note_utf16_byte(txt[i], i == txt.size() - 1);
      @(negedge clk_i);
    end
    n_texts++;
  endtask

  initial begin
    logic [7:0]  txt[$];
    logic [15:0] unit;
    logic        big;
    int          n_units;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 82;

    // noise, big-endian mark, length boundaries, switch to little, zero unit,
    // all-ones unit, trailing odd byte dropped on the final item
    send_utf16_text('{8'h41, BOM_FE, BOM_FF, 8'h00, 8'h41, 8'h07, 8'hFF, 8'h08, 8'h00,
                      BOM_FF, BOM_FE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80});
    // final item with no output
    send_utf16_text('{8'h12});
    // little-endian mark, last one-byte unit, first two-byte unit on final
    send_utf16_text('{BOM_FF, BOM_FE, 8'h7F, 8'h00, 8'h80, 8'h00});

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 82;
        recv_idle_pct = 24;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = LONG_STALL;
      end
      while (sb.n_inputs < 23 + (phase + 1) * (ITEM_TARGET - 23) / 3) begin
        txt.delete();
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(255)));
          big = 1'($urandom_range(1));
          txt.push_back(big ? BOM_FE : BOM_FF);
          txt.push_back(big ? BOM_FF : BOM_FE);
          n_units = $urandom_range(1, 8);
          for (int u = 0; u < n_units; u++) begin
            if ($urandom_range(9) == 0) begin
              big = 1'($urandom_range(1));
              txt.push_back(big ? BOM_FE : BOM_FF);
              txt.push_back(big ? BOM_FF : BOM_FE);
            end else begin
              case ($urandom_range(5))
                0: unit = 16'($urandom_range(16'h007F));
                1: unit = 16'($urandom_range(16'h07FF, 16'h0080));
                2: unit = 16'($urandom_range(16'hFFFF, 16'h0800));
                3: begin
                  case ($urandom_range(5))
                    0: unit = 16'h0000;
                    1: unit = 16'h007F;
                    2: unit = 16'h0080;
                    3: unit = 16'h07FF;
                    4: unit = 16'h0800;
                    default: unit = 16'hFFFF;
                  endcase
                end
                default: unit = 16'($urandom_range(16'hFFFF));
              endcase
              txt.push_back(big ? unit[15:8] : unit[7:0]);
              txt.push_back(big ? unit[7:0] : unit[15:8]);
            end
          end
          if ($urandom_range(5) == 0) txt.push_back(8'($urandom_range(255)));
        end
        send_utf16_text(txt);
      end
    end
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;

    while (sb.utf8_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d UTF-16 bytes in %0d texts, checked %0d UTF-8 bytes",
             sb.n_inputs, n_texts, sb.n_checked);
    $display("Covered both byte orders, order switches, all encoding lengths and stalls");
    if (sb.n_errors == 0 && sb.utf8_pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
